>>> sv/spd_pkg.sv
// ---------------------------------------------------------------------------
// spd_pkg: shared types, constants and the sine table
// Fixed-point constants, the quarter-wave sine table (built at elaboration)
// and the types passed between the front, the queue and the back end.
// ---------------------------------------------------------------------------
package spd_pkg;

  // Table and scaling constants.
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int DUTY_FULL_SCALE  = 100;

  // Full-turn index width, quarter index width and table entry index width.
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH) + 2;
  localparam int QTR_W = IDX_W - 2;
  localparam int ENT_W = QTR_W + 1;
  localparam logic [ENT_W-1:0] DEPTH_E = ENT_W'(SINE_TABLE_DEPTH);
  localparam logic [IDX_W-1:0] COS_OFFSET = IDX_W'(SINE_TABLE_DEPTH);

  // Quadrant codes of the full-turn index.
  localparam logic [1:0] QUAD_FIRST  = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD  = 2'd2;

  localparam logic [15:0] SUPPLY_RESET   = 16'd40960;
  localparam logic [16:0] SQRT3_HALF_Q16 = 17'd56756;
  localparam logic [63:0] Q30_ONE        = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;

  // Datapath widths: Park outputs (Q27), phase voltages (Q43), quotient.
  localparam int PARK_W  = 33;
  localparam int PHASE_W = 50;
  localparam int REM_W   = 26;
  localparam int QUO_W   = 7;
  localparam logic [QUO_W-1:0] DUTY_MAX = QUO_W'(DUTY_FULL_SCALE);

  // Queue between front and back end.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Items held inside the block at most: front stages, queue, back stages.
  localparam int PIPE_CAPACITY = 2 + FIFO_DEPTH + 2 + QUO_W + 1;

  typedef logic [15:0] sine_tbl_t [0:SINE_TABLE_DEPTH];

  // Stator-frame voltages from the inverse Park transform.
  typedef struct packed {
    logic signed [PARK_W-1:0] alpha;
    logic signed [PARK_W-1:0] beta;
  } park_t;

  // One phase in the restoring divider.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             sat;
    logic             zero;
  } phase_div_t;

  // Quarter-wave entry i in Q1.15 from a degree-11 Taylor polynomial in Q30.
  function automatic logic [15:0] quarter_entry(input int unsigned i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] q;
    x  = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    q  = (s + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[15:0];
  endfunction

  function automatic sine_tbl_t build_sine_tbl();
    sine_tbl_t tbl;
    for (int unsigned i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      tbl[i] = quarter_entry(i);
    end
    return tbl;
  endfunction

  localparam sine_tbl_t SINE_TBL = build_sine_tbl();

  // Signed Q1.15 sine at a full-turn index, by quadrant with mirroring.
  function automatic logic signed [15:0] table_sine(input logic [IDX_W-1:0] p);
    logic [1:0]       quad;
    logic [ENT_W-1:0] r;
    logic [ENT_W-1:0] mr;
    logic [15:0]      e_dir;
    logic [15:0]      e_mir;
    logic [15:0]      res;
    quad  = p[IDX_W-1 -: 2];
    r     = {1'b0, p[QTR_W-1:0]};
    mr    = DEPTH_E - r;
    e_dir = SINE_TBL[r];
    e_mir = SINE_TBL[mr];
    case (quad)
      QUAD_FIRST:  res = e_dir;
      QUAD_SECOND: res = e_mir;
      QUAD_THIRD:  res = -e_dir;
      default:     res = -e_mir;
    endcase
    return $signed(res);
  endfunction

endpackage

>>> sv/spd_in_if.sv
// ---------------------------------------------------------------------------
// spd_in_if: input channel
// Valid/ready channel that carries the dq voltages and the electrical angle.
// ---------------------------------------------------------------------------
interface spd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quad_voltage;
  logic signed [15:0] direct_voltage;
  logic [15:0]        elec_angle;

  modport source (
    output valid, quad_voltage, direct_voltage, elec_angle,
    input  ready
  );
  modport sink (
    input  valid, quad_voltage, direct_voltage, elec_angle,
    output ready
  );
endinterface

>>> sv/spd_out_if.sv
// ---------------------------------------------------------------------------
// spd_out_if: result channel
// Valid/ready channel that carries the three phase duty values.
// ---------------------------------------------------------------------------
interface spd_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] duty_a;
  logic [6:0] duty_b;
  logic [6:0] duty_c;

  modport source (
    output valid, duty_a, duty_b, duty_c,
    input  ready
  );
  modport sink (
    input  valid, duty_a, duty_b, duty_c,
    output ready
  );
endinterface

>>> sv/sine_pwm_phase_duty_top.sv
// ---------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not stalled, set by
// the fully pipelined front (table lookup, Park products) and back (Clarke,
// divider). Reset: synchronous, active low; clears all valid state and the
// queue, and sets the supply register to 10 V. No clearing pass is needed.
// ---------------------------------------------------------------------------
// sine_pwm_phase_duty_top: inverse Park/Clarke sine PWM duty generator
// Front end computes the stator-frame voltages, a short queue decouples it
// from the back end that produces the three saturated phase duties.
// ---------------------------------------------------------------------------
module sine_pwm_phase_duty_top (
  input  logic        clk,
  input  logic        rst_n,
  spd_in_if.sink      in_if,
  spd_out_if.source   out_if,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [15:0]    supply_r;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  spd_pkg::park_t q_wdata;
  spd_pkg::park_t q_rdata;

  // Supply voltage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supply_r <= spd_pkg::SUPPLY_RESET;
    end else if (cfg_we) begin
      supply_r <= cfg_wdata;
    end
  end

  spd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  spd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  spd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .supply  (supply_r),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_data  (q_rdata),
    .out_if  (out_if)
  );

endmodule

>>> sv/spd_front.sv
// ---------------------------------------------------------------------------
// spd_front: table lookup and inverse Park transform
// Two stages: sine and cosine lookup, then the four Park products. Stalls
// only when its last stage holds an item and the queue is full.
// ---------------------------------------------------------------------------
module spd_front (
  input  logic           clk,
  input  logic           rst_n,
  spd_in_if.sink         in_if,
  input  logic           q_full,
  output logic           q_push,
  output spd_pkg::park_t q_data
);

  logic                                en;
  logic [spd_pkg::IDX_W-1:0]           p_sin;
  logic [spd_pkg::IDX_W-1:0]           p_cos;

  logic                                f1_valid_r;
  logic signed [15:0]                  f1_sn_r;
  logic signed [15:0]                  f1_cs_r;
  logic signed [15:0]                  f1_uq_r;
  logic signed [15:0]                  f1_ud_r;

  logic signed [31:0]                  ud_cs;
  logic signed [31:0]                  uq_sn;
  logic signed [31:0]                  ud_sn;
  logic signed [31:0]                  uq_cs;
  spd_pkg::park_t                      park_nxt;

  logic                                f2_valid_r;
  spd_pkg::park_t                      f2_park_r;

  // The whole front advances unless a finished item cannot enter the queue.
  assign en          = !(f2_valid_r && q_full);
  assign in_if.ready = en;

  // Full-turn index of the angle; the cosine sits a quarter turn ahead.
  assign p_sin = in_if.elec_angle[15 -: spd_pkg::IDX_W];
  assign p_cos = p_sin + spd_pkg::COS_OFFSET;

  // Stage one: table lookups.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (en) begin
      f1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_sn_r <= spd_pkg::table_sine(p_sin);
      f1_cs_r <= spd_pkg::table_sine(p_cos);
      f1_uq_r <= in_if.quad_voltage;
      f1_ud_r <= in_if.direct_voltage;
    end
  end

  // Stage two: alpha = Ud cos - Uq sin, beta = Ud sin + Uq cos, in Q27.
  assign ud_cs = f1_ud_r * f1_cs_r;
  assign uq_sn = f1_uq_r * f1_sn_r;
  assign ud_sn = f1_ud_r * f1_sn_r;
  assign uq_cs = f1_uq_r * f1_cs_r;

  always_comb begin
    park_nxt.alpha = spd_pkg::PARK_W'(ud_cs) - spd_pkg::PARK_W'(uq_sn);
    park_nxt.beta  = spd_pkg::PARK_W'(ud_sn) + spd_pkg::PARK_W'(uq_cs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_valid_r <= 1'b0;
    end else if (en) begin
      f2_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_park_r <= park_nxt;
    end
  end

  // Hand the item to the queue.
  assign q_push = en && f2_valid_r;
  assign q_data = f2_park_r;

endmodule

>>> sv/spd_fifo.sv
// ---------------------------------------------------------------------------
// spd_fifo: short queue between front and back end
// Holds Park results so that each side can stall on its own.
// ---------------------------------------------------------------------------
module spd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  spd_pkg::park_t push_data,
  output logic           full,
  input  logic           pop,
  output spd_pkg::park_t pop_data,
  output logic           empty
);

  spd_pkg::park_t                   mem_r [0:spd_pkg::FIFO_DEPTH-1];
  logic [spd_pkg::FIFO_PTR_W-1:0]   wr_ptr_r;
  logic [spd_pkg::FIFO_PTR_W-1:0]   rd_ptr_r;
  logic [spd_pkg::FIFO_CNT_W-1:0]   count_r;
  logic [spd_pkg::FIFO_CNT_W-1:0]   count_nxt;

  assign full     = (count_r == spd_pkg::FIFO_CNT_W'(spd_pkg::FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> sv/spd_back.sv
// ---------------------------------------------------------------------------
// spd_back: inverse Clarke transform and duty scaling
// Forms the three phase voltages, scales them to the supply and finds the
// percent duty with a seven-stage restoring divider, then saturates.
// ---------------------------------------------------------------------------
module spd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [15:0]    supply,
  input  logic           q_empty,
  output logic           q_pop,
  input  spd_pkg::park_t q_data,
  spd_out_if.source      out_if
);

  localparam int PW   = spd_pkg::PHASE_W;
  localparam int RW   = spd_pkg::REM_W;
  localparam int QW   = spd_pkg::QUO_W;
  localparam int XW   = PW + 7;

  logic                        en;

  logic signed [PW-1:0]        a_ext;
  logic signed [PW-1:0]        a_half;
  logic signed [PW-1:0]        b_part;
  logic signed [PW-1:0]        mid;
  logic signed [spd_pkg::PARK_W+17:0] beta_k;
  logic signed [PW-1:0]        u_nxt [0:2];

  logic                        b1_valid_r;
  logic signed [PW-1:0]        u_r [0:2];

  spd_pkg::phase_div_t         st0_nxt [0:2];
  spd_pkg::phase_div_t         st_nxt  [1:QW][0:2];
  spd_pkg::phase_div_t         st_r    [0:QW][0:2];
  logic                        st_valid_r [0:QW];

  logic [RW-1:0]               sat_lim;

  logic                        out_valid_r;
  logic [QW-1:0]               duty_r [0:2];

  // The back end advances whenever the output register is free or taken.
  assign en    = !out_valid_r || out_if.ready;
  assign q_pop = en && !q_empty;

  // Inverse Clarke in Q43, offset by half the supply.
  assign a_ext  = PW'(q_data.alpha);
  assign a_half = a_ext <<< 15;
  assign beta_k = q_data.beta * $signed({1'b0, spd_pkg::SQRT3_HALF_Q16});
  assign b_part = PW'(beta_k);
  assign mid    = $signed({{(PW-46){1'b0}}, supply, 30'b0});

  always_comb begin
    u_nxt[0] = (a_ext <<< 16) + mid;
    u_nxt[1] = b_part - a_half + mid;
    u_nxt[2] = mid - a_half - b_part;
  end

  // Scale by the full-scale count and drop the Q31 fraction of the divisor.
  always_comb begin
    logic signed [XW-1:0] ux;
    logic signed [XW-1:0] u100;
    for (int k = 0; k < 3; k++) begin
      ux              = XW'(u_r[k]);
      u100            = (ux <<< 6) + (ux <<< 5) + (ux <<< 2);
      st0_nxt[k].rem  = u100[RW+30:31];
      st0_nxt[k].quo  = '0;
      st0_nxt[k].sat  = 1'b0;
      st0_nxt[k].zero = u_r[k][PW-1] || (u_r[k] == '0) || (supply == '0);
    end
  end

  // Restoring divider, one quotient bit per stage; the first stage also
  // flags a quotient too large for the divider.
  assign sat_lim = RW'(supply) << QW;

  always_comb begin
    logic [RW-1:0]       dv;
    spd_pkg::phase_div_t cur;
    spd_pkg::phase_div_t nx;
    for (int s = 0; s < QW; s++) begin
      for (int k = 0; k < 3; k++) begin
        dv  = RW'(supply) << (QW - 1 - s);
        cur = st_r[s][k];
        nx  = cur;
        if (cur.rem >= dv) begin
          nx.rem = cur.rem - dv;
          nx.quo = cur.quo | (QW'(1) << (QW - 1 - s));
        end
        if (s == 0) begin
          nx.sat = (cur.rem >= sat_lim);
        end
        st_nxt[s+1][k] = nx;
      end
    end
  end

  // Valid bits of the back-end stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int s = 0; s <= QW; s++) begin
        st_valid_r[s] <= 1'b0;
      end
    end else if (en) begin
      b1_valid_r    <= !q_empty;
      st_valid_r[0] <= b1_valid_r;
      for (int s = 1; s <= QW; s++) begin
        st_valid_r[s] <= st_valid_r[s-1];
      end
      out_valid_r   <= st_valid_r[QW];
    end
  end

  // Payload of the back-end stages and the saturated duty values.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        u_r[k]      <= u_nxt[k];
        st_r[0][k]  <= st0_nxt[k];
        for (int s = 1; s <= QW; s++) begin
          st_r[s][k] <= st_nxt[s][k];
        end
        if (st_r[QW][k].zero) begin
          duty_r[k] <= '0;
        end else if (st_r[QW][k].sat || (st_r[QW][k].quo > spd_pkg::DUTY_MAX)) begin
          duty_r[k] <= spd_pkg::DUTY_MAX;
        end else begin
          duty_r[k] <= st_r[QW][k].quo;
        end
      end
    end
  end

  assign out_if.valid  = out_valid_r;
  assign out_if.duty_a = duty_r[0];
  assign out_if.duty_b = duty_r[1];
  assign out_if.duty_c = duty_r[2];

endmodule

>>> sv/spd_checker.sv
// ---------------------------------------------------------------------------
// spd_checker: port-level checks of the duty generator
// Watches the channels of the top level and tracks the items in flight.
// ---------------------------------------------------------------------------
module spd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] duty_a,
  input logic [6:0] duty_b,
  input logic [6:0] duty_c
);

  localparam int CNT_W = $clog2(spd_pkg::PIPE_CAPACITY + 1) + 1;

  logic             in_acc;
  logic             out_acc;
  logic [CNT_W-1:0] pend_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Items accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_acc && !out_acc) begin
      pend_r <= pend_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  // A stalled result stays and keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(duty_a) && $stable(duty_b)
      && $stable(duty_c))
    else $error("result changed while stalled");

  // Duties never leave the full-scale range.
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (duty_a <= 7'(spd_pkg::DUTY_FULL_SCALE))
      && (duty_b <= 7'(spd_pkg::DUTY_FULL_SCALE))
      && (duty_c <= 7'(spd_pkg::DUTY_FULL_SCALE)))
    else $error("duty above full scale");

  // No result without an earlier accepted item.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != '0)
    else $error("result delivered with no item in flight");

  // The block never holds more items than its stages and queue.
  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= CNT_W'(spd_pkg::PIPE_CAPACITY))
    else $error("more items in flight than the pipeline holds");

  // Reset empties the output.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind sine_pwm_phase_duty_top spd_checker u_spd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .duty_a    (out_if.duty_a),
  .duty_b    (out_if.duty_b),
  .duty_c    (out_if.duty_c)
);

>>> test/sine_pwm_phase_duty_top_tb.sv
// ---------------------------------------------------------------------------
// sine_pwm_phase_duty_top_tb: self-checking bench for the sine PWM duty block
// Sends dq voltage and angle items through the input channel, predicts the
// three phase duties with an independent fixed-point model of the inverse
// Park and Clarke transforms, and checks every result item in order. Covers
// field extremes, saturation at both ends, several supply settings including
// zero, and random traffic with idle cycles and back-pressure on both sides.
// ---------------------------------------------------------------------------
module sine_pwm_phase_duty_top_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PHASE_ITEMS    = 130;
  localparam int SWEEP_PHASES   = 5;

  // One input item: dq voltages and the electrical angle.
  typedef struct {
    logic signed [15:0] quad_voltage;
    logic signed [15:0] direct_voltage;
    logic [15:0]        elec_angle;
  } phase_cmd_t;

  // One result item: the three phase duties.
  typedef struct {
    logic [6:0] duty_a;
    logic [6:0] duty_b;
    logic [6:0] duty_c;
  } duty_set_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  spd_in_if  in_ch ();
  spd_out_if out_ch ();

  // Bench copy of the supply register and of the quarter-wave sine table.
  logic [15:0] supply_model;
  logic [15:0] quarter_sine_tbl [0:spd_pkg::SINE_TABLE_DEPTH];

  duty_set_t duty_expect_q [$];
  bit        no_gaps;
  int        mismatch_count;
  int        quiet_cycles = 0;

  sine_pwm_phase_duty_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Quarter-wave entry in Q1.15: Taylor series of degree 11 in Q30, Horner form.
  function automatic logic [15:0] taylor_quarter_sine(input int unsigned idx);
    logic [63:0] ang_q30;
    logic [63:0] sq_q30;
    logic [63:0] poly;
    logic [63:0] rounded;
    int unsigned divisor [5] = '{110, 72, 42, 20, 6};
    ang_q30 = (spd_pkg::HALF_PI_Q30 * 64'(idx)) / 64'(spd_pkg::SINE_TABLE_DEPTH);
    sq_q30  = (ang_q30 * ang_q30) >> 30;
    poly    = spd_pkg::Q30_ONE;
    for (int k = 0; k < 5; k++) begin
      poly = spd_pkg::Q30_ONE - ((sq_q30 * poly) >> 30) / 64'(divisor[k]);
    end
    rounded = (((ang_q30 * poly) >> 30) + 64'd16384) >> 15;
    if (rounded > 64'd32767) begin
      rounded = 64'd32767;
    end
    return rounded[15:0];
  endfunction

  // Signed sine at a full-turn index, mirrored and negated by quadrant.
  function automatic longint sine_at(input logic [spd_pkg::IDX_W-1:0] idx);
    logic [spd_pkg::QTR_W-1:0] r;
    r = idx[spd_pkg::QTR_W-1:0];
    case (idx[spd_pkg::IDX_W-1 -: 2])
      spd_pkg::QUAD_FIRST:  return longint'(quarter_sine_tbl[r]);
      spd_pkg::QUAD_SECOND: return longint'(quarter_sine_tbl[spd_pkg::SINE_TABLE_DEPTH - r]);
      spd_pkg::QUAD_THIRD:  return -longint'(quarter_sine_tbl[r]);
      default:              return -longint'(quarter_sine_tbl[spd_pkg::SINE_TABLE_DEPTH - r]);
    endcase
  endfunction

  // Percent duty of one Q43 phase voltage, truncated and clamped to 0..100.
  function automatic logic [6:0] duty_from_phase(input longint u43, input longint denom);
    longint pct;
    pct = (u43 * spd_pkg::DUTY_FULL_SCALE) / denom;
    if (pct < 0) begin
      pct = 0;
    end
    if (pct > spd_pkg::DUTY_FULL_SCALE) begin
      pct = spd_pkg::DUTY_FULL_SCALE;
    end
    return 7'(pct);
  endfunction

  // Expected duties for one item at the current supply setting.
  function automatic duty_set_t predict_phase_duties(input phase_cmd_t c);
    logic [spd_pkg::IDX_W-1:0] p;
    logic [spd_pkg::IDX_W-1:0] pc;
    longint p_full;
    longint uq;
    longint ud;
    longint sn;
    longint cs;
    longint alpha;
    longint beta;
    longint v;
    longint sqrt3h;
    longint denom;
    duty_set_t d;
    uq = c.quad_voltage;
    ud = c.direct_voltage;
    p_full = (longint'(c.elec_angle) * 4 * spd_pkg::SINE_TABLE_DEPTH) >>> 16;
    p  = p_full[spd_pkg::IDX_W-1:0];
    pc = p + spd_pkg::COS_OFFSET;
    sn = sine_at(p);
    cs = sine_at(pc);
    alpha = ud * cs - uq * sn;
    beta  = ud * sn + uq * cs;
    v = longint'(supply_model);
    if (v == 0) begin
      d.duty_a = 7'd0;
      d.duty_b = 7'd0;
      d.duty_c = 7'd0;
      return d;
    end
    sqrt3h = longint'(spd_pkg::SQRT3_HALF_Q16);
    denom  = v <<< 31;
    d.duty_a = duty_from_phase(alpha * 65536 + (v <<< 30), denom);
    d.duty_b = duty_from_phase(-alpha * 32768 + beta * sqrt3h + (v <<< 30), denom);
    d.duty_c = duty_from_phase(-alpha * 32768 - beta * sqrt3h + (v <<< 30), denom);
    return d;
  endfunction

  // Random item; bounded items keep the phase swing mostly inside the supply.
  function automatic phase_cmd_t random_cmd(input bit full_range);
    phase_cmd_t c;
    int amp;
    amp = int'(supply_model) / 3;
    if (full_range) begin
      c.quad_voltage   = 16'($urandom);
      c.direct_voltage = 16'($urandom);
    end else begin
      c.quad_voltage   = 16'(int'($urandom_range(0, 2 * amp)) - amp);
      c.direct_voltage = 16'(int'($urandom_range(0, 2 * amp)) - amp);
    end
    c.elec_angle = 16'($urandom);
    return c;
  endfunction

  // Sends one item after a random gap and records its expected duties.
  task automatic send_cmd(input phase_cmd_t cmd);
    while (!no_gaps && $urandom_range(0, 99) < 33) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.quad_voltage   <= cmd.quad_voltage;
    in_ch.direct_voltage <= cmd.direct_voltage;
    in_ch.elec_angle     <= cmd.elec_angle;
    do @(posedge clk); while (!in_ch.ready);
    duty_expect_q.push_back(predict_phase_duties(cmd));
    @(negedge clk);
  endtask

  // Holds the sender back until every expected result has arrived.
  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (duty_expect_q.size() != 0);
  endtask

  // Writes the supply register once the block has emptied.
  task automatic write_supply(input logic [15:0] value);
    wait_results_done();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    supply_model = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Field extremes, quadrant boundaries and saturation at both ends.
  task automatic test_field_extremes();
    phase_cmd_t corner_cmds [10] = '{
      '{16'sh0000, 16'sh0000, 16'h0000},
      '{16'sh7FFF, 16'sh0000, 16'h4000},
      '{16'sh8000, 16'sh0000, 16'h4000},
      '{16'sh0000, 16'sh7FFF, 16'h0000},
      '{16'sh0000, 16'sh8000, 16'h0000},
      '{16'sh7FFF, 16'sh7FFF, 16'h8000},
      '{16'sh8000, 16'sh8000, 16'hC000},
      '{16'sh3000, 16'shF000, 16'hFFFF},
      '{16'shE000, 16'sh4000, 16'h3FC0},
      '{16'sh1000, 16'sh1000, 16'h2AAA}
    };
    foreach (corner_cmds[i]) begin
      send_cmd(corner_cmds[i]);
    end
  endtask

  // Supply of zero, the smallest non-zero supply and the range limits.
  task automatic test_supply_corners();
    phase_cmd_t probe_cmds [2] = '{
      '{16'sh7FFF, 16'sh8000, 16'h1234},
      '{16'sh0400, 16'shFC00, 16'hFFFF}
    };
    write_supply(16'd0);
    foreach (probe_cmds[i]) send_cmd(probe_cmds[i]);
    write_supply(16'd1);
    send_cmd(probe_cmds[1]);
    write_supply(16'hFFFF);
    foreach (probe_cmds[i]) send_cmd(probe_cmds[i]);
    write_supply(16'd4096);
    foreach (probe_cmds[i]) send_cmd(probe_cmds[i]);
  endtask

  // Random items over a range of supply settings; one phase runs without gaps.
  task automatic test_random_sweep();
    logic [15:0] sweep_supply [SWEEP_PHASES];
    sweep_supply = '{16'hFFFF, 16'd4096, 16'($urandom_range(4096, 65535)),
                     spd_pkg::SUPPLY_RESET, 16'($urandom)};
    for (int ph = 0; ph < SWEEP_PHASES; ph++) begin
      write_supply(sweep_supply[ph]);
      no_gaps = (ph == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Let the pipeline run dry halfway through some phases.
        if (n == PHASE_ITEMS / 2 && ph % 2 == 1) begin
          wait_results_done();
        end
        send_cmd(random_cmd($urandom_range(0, 3) == 0));
      end
    end
    no_gaps = 1'b0;
  endtask

  // Result side back-pressure, switched off during the gap-free phase.
  always @(negedge clk) begin
    out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 33);
  end

  // Compares each result item with the oldest expectation.
  always @(posedge clk) begin : check_duties
    duty_set_t exp_d;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (duty_expect_q.size() == 0) begin
        $error("unexpected result item: duty_a %0d duty_b %0d duty_c %0d",
               out_ch.duty_a, out_ch.duty_b, out_ch.duty_c);
        mismatch_count++;
      end else begin
        exp_d = duty_expect_q.pop_front();
        if (out_ch.duty_a !== exp_d.duty_a) begin
          $error("duty_a: expected %0d, got %0d", exp_d.duty_a, out_ch.duty_a);
          mismatch_count++;
        end
        if (out_ch.duty_b !== exp_d.duty_b) begin
          $error("duty_b: expected %0d, got %0d", exp_d.duty_b, out_ch.duty_b);
          mismatch_count++;
        end
        if (out_ch.duty_c !== exp_d.duty_c) begin
          $error("duty_c: expected %0d, got %0d", exp_d.duty_c, out_ch.duty_c);
          mismatch_count++;
        end
      end
    end
  end

  // Ends the run when nothing has been accepted for too long.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Reset, the test sequence and the final verdict.
  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = 16'd0;
    in_ch.valid          = 1'b0;
    in_ch.quad_voltage   = 16'sd0;
    in_ch.direct_voltage = 16'sd0;
    in_ch.elec_angle     = 16'd0;
    out_ch.ready         = 1'b0;
    no_gaps              = 1'b0;
    mismatch_count       = 0;
    supply_model         = spd_pkg::SUPPLY_RESET;
    for (int i = 0; i <= spd_pkg::SINE_TABLE_DEPTH; i++) begin
      quarter_sine_tbl[i] = taylor_quarter_sine(i);
    end
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_supply_corners();
    test_random_sweep();

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (duty_expect_q.size() != 0) begin
      $error("%0d expected result items never arrived", duty_expect_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/spd_pkg.sv
sv/spd_in_if.sv
sv/spd_out_if.sv
sv/spd_front.sv
sv/spd_fifo.sv
sv/spd_back.sv
sv/sine_pwm_phase_duty_top.sv
sv/spd_checker.sv
test/sine_pwm_phase_duty_top_tb.sv
